// ===== rtl/ppmfd_pkg.sv =====
// Package for the PPM frame decoder: register indexes, reset values,
// pulse kinds, frame phases and the result word layout.
// No dependencies; every other file in rtl/ imports it.
package ppmfd_pkg;

    // Parameter defaults
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int LENGTH_BITS_DEF  = 16;

    // Field widths fixed by the interface
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 17;

    // Register reset values
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd32700;
    localparam logic [CFG_DATA_W-1:0]      SYNC_MIN_RST  = 16'd5000;
    localparam logic [CFG_DATA_W-1:0]      SYNC_MAX_RST  = 16'd20000;
    localparam logic [COUNT_W-1:0]         CHAN_CNT_RST  = 5'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SYNC_MIN  = 2'd1,
        REG_SYNC_MAX  = 2'd2,
        REG_CHAN_CNT  = 2'd3
    } t_reg_idx;

    // Classification of a finished pulse
    typedef enum logic [1:0] {
        KIND_LOW     = 2'd0,
        KIND_HIGH    = 2'd1,
        KIND_SYNC    = 2'd2,
        KIND_INVALID = 2'd3
    } t_kind;

    // Frame machine phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT       = 5'b00001,
        PH_CH_HIGH    = 5'b00010,
        PH_CH_LOW     = 5'b00100,
        PH_TRAIL_HIGH = 5'b01000,
        PH_TRAIL_SYNC = 5'b10000
    } t_phase;

    // Finished pulse event from the pulse measurer
    typedef struct packed {
        logic  done;
        t_kind kind;
    } t_pulse;

    // One result word
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_result;

endpackage

// ===== rtl/ppmfd_pulse.sv =====
// Pulse measurer: slices samples into high/low, counts run lengths and
// classifies each finished pulse. Depends on ppmfd_pkg.
module ppmfd_pulse
    import ppmfd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    input  logic signed [SAMPLE_W-1:0]   i_threshold,
    input  logic        [CFG_DATA_W-1:0] i_sync_min,
    input  logic        [CFG_DATA_W-1:0] i_sync_max,
    output t_pulse                       o_pulse,
    output logic        [LENGTH_BITS-1:0] o_len
);

    localparam int CMP_W = (LENGTH_BITS > CFG_DATA_W) ? LENGTH_BITS : CFG_DATA_W;

    logic                   r_started;
    logic                   r_is_high;
    logic [LENGTH_BITS-1:0] r_len;
    logic                   n_started;
    logic                   n_is_high;
    logic [LENGTH_BITS-1:0] n_len;

    logic             hi;
    logic             flip;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] min_ext;
    logic [CMP_W-1:0] max_ext;

    // Slice the sample against the threshold
    assign hi   = i_sample > i_threshold;
    assign flip = r_started && (hi != r_is_high);

    assign len_ext = CMP_W'(r_len);
    assign min_ext = CMP_W'(i_sync_min);
    assign max_ext = CMP_W'(i_sync_max);

    // Classify the pulse that the flipping sample ends
    always_comb begin
        o_pulse.done = i_step && flip;
        if (len_ext >= min_ext) begin
            o_pulse.kind = (!r_is_high && len_ext <= max_ext) ? KIND_SYNC : KIND_INVALID;
        end else begin
            o_pulse.kind = r_is_high ? KIND_HIGH : KIND_LOW;
        end
    end
    assign o_len = r_len;

    // Advance the run-length counter, saturating at all ones
    always_comb begin
        n_started = r_started;
        n_is_high = r_is_high;
        n_len     = r_len;
        if (i_step) begin
            n_started = 1'b1;
            if (!r_started || flip) begin
                n_is_high = hi;
                n_len     = LENGTH_BITS'(1);
            end else if (r_len != '1) begin
                n_len = r_len + LENGTH_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_is_high <= 1'b0;
            r_len     <= '0;
        end else begin
            r_started <= n_started;
            r_is_high <= n_is_high;
            r_len     <= n_len;
        end
    end

endmodule

// ===== rtl/ppmfd_frame.sv =====
// Frame machine: hunts for sync, pairs high and low pulses into channel
// words and checks the trailer. Depends on ppmfd_pkg.
module ppmfd_frame
    import ppmfd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  t_pulse                 i_pulse,
    input  logic [LENGTH_BITS-1:0] i_len,
    input  logic [COUNT_W-1:0]     i_chan_cnt,
    output t_result                o_res
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = ((CH_W > COUNT_W) ? CH_W : COUNT_W) + 1;
    localparam int SUM_W = LENGTH_BITS + 1;

    t_phase                 r_phase;
    logic [CH_W-1:0]        r_chan;
    logic [LENGTH_BITS-1:0] r_high_len;
    t_phase                 n_phase;
    logic [CH_W-1:0]        n_chan;
    logic [LENGTH_BITS-1:0] n_high_len;

    logic [CNT_W-1:0]         cnt_raw;
    logic [CNT_W-1:0]         eff_cnt;
    logic [CNT_W-1:0]         chan_next;
    logic                     is_last;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W+VALUE_W-1:0] sum_ext;
    logic [CH_W+INDEX_W-1:0]  chan_ext;

    // Clamp the channel count into one to MAX_CHANNELS
    always_comb begin
        cnt_raw = CNT_W'(i_chan_cnt);
        if (cnt_raw == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (cnt_raw > CNT_W'(MAX_CHANNELS)) begin
            eff_cnt = CNT_W'(MAX_CHANNELS);
        end else begin
            eff_cnt = cnt_raw;
        end
    end

    assign chan_next = CNT_W'(r_chan) + CNT_W'(1);
    assign is_last   = chan_next >= eff_cnt;
    assign sum       = {1'b0, r_high_len} + {1'b0, i_len};
    assign sum_ext   = {{VALUE_W{1'b0}}, sum};
    assign chan_ext  = {{INDEX_W{1'b0}}, r_chan};

    // Step the frame phase on each finished pulse
    always_comb begin
        n_phase     = r_phase;
        n_chan      = r_chan;
        n_high_len  = r_high_len;
        o_res.valid = 1'b0;
        o_res.last  = is_last;
        o_res.index = chan_ext[INDEX_W-1:0];
        o_res.value = sum_ext[VALUE_W-1:0];
        if (i_step && i_pulse.done) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_pulse.kind == KIND_SYNC) begin
                        n_phase    = PH_CH_HIGH;
                        n_chan     = '0;
                        n_high_len = '0;
                    end
                end
                PH_CH_HIGH: begin
                    if (i_pulse.kind == KIND_HIGH) begin
                        n_high_len = i_len;
                        n_phase    = PH_CH_LOW;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_CH_LOW: begin
                    if (i_pulse.kind != KIND_LOW) begin
                        n_phase = PH_HUNT;
                    end else begin
                        o_res.valid = 1'b1;
                        if (is_last) begin
                            n_phase = PH_TRAIL_HIGH;
                        end else begin
                            n_chan  = chan_next[CH_W-1:0];
                            n_phase = PH_CH_HIGH;
                        end
                    end
                end
                PH_TRAIL_HIGH: begin
                    n_phase = (i_pulse.kind == KIND_HIGH) ? PH_TRAIL_SYNC : PH_HUNT;
                end
                PH_TRAIL_SYNC: begin
                    if (i_pulse.kind == KIND_SYNC) begin
                        n_phase    = PH_CH_HIGH;
                        n_chan     = '0;
                        n_high_len = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_chan     <= '0;
            r_high_len <= '0;
        end else begin
            r_phase    <= n_phase;
            r_chan     <= n_chan;
            r_high_len <= n_high_len;
        end
    end

    // A word leaves only from the low half of a channel
    a_res_from_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_phase == PH_CH_LOW && i_step && i_pulse.done))
        else $error("channel word outside low phase");

    // The last channel of a frame moves on to the trailer
    a_last_to_trail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |=> (r_phase == PH_TRAIL_HIGH))
        else $error("last channel did not enter trailer");

    // Hold the phase while no pulse finishes
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_pulse.done) |=> $stable(r_phase) && $stable(r_chan))
        else $error("frame state moved without a pulse");

    // Keep the channel index inside the table
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_chan) < CNT_W'(MAX_CHANNELS))
        else $error("channel index out of range");

endmodule

// ===== rtl/ppm_frame_decoder_top.sv =====
// PPM frame decoder top level: an accepted sample waits in the input register,
// then its word is loaded into the result register; throughput one sample per
// cycle unless the result word stalls, set by the single-pass step between the registers.
// A stalled result word holds the result register; one more sample is held
// in the input register meanwhile. Synchronous active-low reset clears the
// pulse and frame state and loads the register defaults; no clearing pass.
module ppm_frame_decoder_top
    import ppmfd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    // channel word output
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [INDEX_W-1:0]         o_channel_index,
    output logic [VALUE_W-1:0]         o_channel_value,
    output logic                       o_last_of_frame,
    // configuration writes
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic signed [SAMPLE_W-1:0]   r_threshold;
    logic        [CFG_DATA_W-1:0] r_sync_min;
    logic        [CFG_DATA_W-1:0] r_sync_max;
    logic        [COUNT_W-1:0]    r_chan_cnt;

    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    t_result                    r_out;
    logic                       n_out_valid;

    logic                   step;
    t_pulse                 pulse;
    logic [LENGTH_BITS-1:0] pulse_len;
    t_result                res;

    // Advance the held sample when the result slot is free or draining
    assign step    = r_in_valid && (!r_out.valid || i_ready);
    assign o_ready = !r_in_valid || step;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_sync_min  <= SYNC_MIN_RST;
            r_sync_max  <= SYNC_MAX_RST;
            r_chan_cnt  <= CHAN_CNT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_THRESHOLD: r_threshold <= $signed(i_cfg_data);
                REG_SYNC_MIN:  r_sync_min  <= i_cfg_data;
                REG_SYNC_MAX:  r_sync_max  <= i_cfg_data;
                REG_CHAN_CNT:  r_chan_cnt  <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

    ppmfd_pulse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_pulse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sample    (r_sample),
        .i_threshold (r_threshold),
        .i_sync_min  (r_sync_min),
        .i_sync_max  (r_sync_max),
        .o_pulse     (pulse),
        .o_len       (pulse_len)
    );

    ppmfd_frame #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_pulse    (pulse),
        .i_len      (pulse_len),
        .i_chan_cnt (r_chan_cnt),
        .o_res      (res)
    );

    // Load a new word, or drop the one just taken
    always_comb begin
        n_out_valid = r_out.valid;
        if (r_out.valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (step && res.valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= n_out_valid;
            if (step && res.valid) begin
                r_out.last  <= res.last;
                r_out.index <= res.index;
                r_out.value <= res.value;
            end
        end
    end

    assign o_valid         = r_out.valid;
    assign o_channel_index = r_out.index;
    assign o_channel_value = r_out.value;
    assign o_last_of_frame = r_out.last;

endmodule

// ===== dv/ppm_frame_decoder_top_tb.sv =====
// Testbench for ppm_frame_decoder_top: a directed table and random pulse trains
// under changing register settings; every channel word is checked against an
// in-bench frame decoder. Depends on rtl/ppmfd_pkg.sv and ppm_frame_decoder_top.
module ppm_frame_decoder_top_tb;
    import ppmfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 37;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RANDOM_SAMPLES = 520;
    localparam int RANDOM_WORDS   = 40;
    localparam int CALM_FIRST     = 250;
    localparam int CALM_LAST      = 450;
    localparam int SCRIPT_LEN     = 29;

    typedef struct packed {
        logic [INDEX_W-1:0] chan;
        logic [VALUE_W-1:0] sum;
        logic               last;
    } t_chan_word;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_WORD} t_row_exp;

    typedef struct packed {
        t_row_kind   kind;
        t_reg_idx    sel;
        logic [15:0] data;
        t_row_exp    how;
        t_chan_word  word;
    } t_step_row;

    localparam t_chan_word NO_WORD = '0;

    // Reset-value samples, four writes, then sync, two channels, second sync, over-long high pulse
    localparam t_step_row DIRECTED_STEPS [SCRIPT_LEN] = '{
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h7FFF, EXP_NONE,  NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h8000, EXP_NONE,  NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'd32700, EXP_NONE, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'd32701, EXP_NONE, NO_WORD},
        '{ROW_WRITE,  REG_THRESHOLD, 16'd0,    EXP_MODEL, NO_WORD},
        '{ROW_WRITE,  REG_SYNC_MIN,  16'd4,    EXP_MODEL, NO_WORD},
        '{ROW_WRITE,  REG_SYNC_MAX,  16'd5,    EXP_MODEL, NO_WORD},
        '{ROW_WRITE,  REG_CHAN_CNT,  16'd2,    EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0000, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h8000, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFE, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0001, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h7FFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFD, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFC, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0002, EXP_WORD,  '{4'd0, 17'd4, 1'b0}},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0003, EXP_WORD,  '{4'd1, 17'd2, 1'b1}},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0001, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0001, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0001, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'h0001, EXP_MODEL, NO_WORD},
        '{ROW_SAMPLE, REG_THRESHOLD, 16'hFFFF, EXP_MODEL, NO_WORD}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [INDEX_W-1:0]         o_channel_index;
    logic [VALUE_W-1:0]         o_channel_value;
    logic                       o_last_of_frame;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    // Register copies held by the decoder model
    logic signed [15:0] cfg_thr;
    logic [15:0]        cfg_smin;
    logic [15:0]        cfg_smax;
    logic [4:0]         cfg_cnt;

    // Pulse and frame state of the decoder model
    logic        pl_started;
    logic        pl_high;
    logic [15:0] pl_len;
    t_phase      fr_phase;
    int          fr_chan;
    logic [15:0] fr_high_len;

    t_chan_word  words_due[$];
    t_chan_word  word_want;
    int          samples_sent;
    int          words_predicted;
    int          words_checked;
    int          settings_used;
    int          mismatches;
    int unsigned cycle_count = 0;

    ppm_frame_decoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     words_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit steady_flow();
        return samples_sent >= CALM_FIRST && samples_sent < CALM_LAST;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int channels_per_frame();
        if (cfg_cnt == 0)
            return 1;
        if (cfg_cnt > MAX_CHANNELS_DEF)
            return MAX_CHANNELS_DEF;
        return cfg_cnt;
    endfunction

    function automatic void reset_decoder();
        cfg_thr     = THRESHOLD_RST;
        cfg_smin    = SYNC_MIN_RST;
        cfg_smax    = SYNC_MAX_RST;
        cfg_cnt     = CHAN_CNT_RST;
        pl_started  = 1'b0;
        pl_high     = 1'b0;
        pl_len      = '0;
        fr_phase    = PH_HUNT;
        fr_chan     = 0;
        fr_high_len = '0;
    endfunction

    // Measure pulses, classify each finished one and advance the frame machine
    function automatic void decode_sample(input logic signed [15:0] s, output bit made,
                                          output t_chan_word w);
        logic        hi;
        logic [15:0] len;
        t_kind       kind;
        made = 1'b0;
        w    = NO_WORD;
        hi   = s > cfg_thr;
        if (!pl_started) begin
            pl_started = 1'b1;
            pl_high    = hi;
            pl_len     = 16'd1;
            return;
        end
        if (hi == pl_high) begin
            if (pl_len != 16'hFFFF)
                pl_len++;
            return;
        end
        len  = pl_len;
        kind = pl_high ? KIND_HIGH : KIND_LOW;
        if (len >= cfg_smin)
            kind = (!pl_high && len <= cfg_smax) ? KIND_SYNC : KIND_INVALID;
        pl_high = hi;
        pl_len  = 16'd1;
        case (fr_phase)
            PH_HUNT: begin
                if (kind == KIND_SYNC) begin
                    fr_phase = PH_CH_HIGH;
                    fr_chan  = 0;
                end
            end
            PH_CH_HIGH: begin
                if (kind == KIND_HIGH) begin
                    fr_high_len = len;
                    fr_phase    = PH_CH_LOW;
                end else begin
                    fr_phase = PH_HUNT;
                end
            end
            PH_CH_LOW: begin
                if (kind != KIND_LOW) begin
                    fr_phase = PH_HUNT;
                end else begin
                    made   = 1'b1;
                    w.chan = fr_chan[INDEX_W-1:0];
                    w.sum  = {1'b0, fr_high_len} + {1'b0, len};
                    w.last = fr_chan + 1 >= channels_per_frame();
                    if (w.last) begin
                        fr_phase = PH_TRAIL_HIGH;
                    end else begin
                        fr_chan++;
                        fr_phase = PH_CH_HIGH;
                    end
                end
            end
            PH_TRAIL_HIGH: begin
                fr_phase = (kind == KIND_HIGH) ? PH_TRAIL_SYNC : PH_HUNT;
            end
            PH_TRAIL_SYNC: begin
                if (kind == KIND_SYNC) begin
                    fr_phase = PH_CH_HIGH;
                    fr_chan  = 0;
                end else begin
                    fr_phase = PH_HUNT;
                end
            end
            default: fr_phase = PH_HUNT;
        endcase
    endfunction

    // Offer one sample word, hold it until accepted, then predict its channel word
    task automatic push_sample(input logic signed [15:0] s, input t_row_exp how,
                               input t_chan_word typed);
        bit         made;
        t_chan_word got;
        while (!steady_flow() && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        samples_sent++;
        decode_sample(s, made, got);
        case (how)
            EXP_MODEL: begin
                if (made) begin
                    words_due.push_back(got);
                    words_predicted++;
                end
            end
            EXP_NONE: begin
                if (made)
                    flag_mismatch($sformatf("model gives a word for sample %0d", s));
            end
            default: begin
                words_due.push_back(typed);
                if (!made || got != typed)
                    flag_mismatch($sformatf("model disagrees with table at sample %0d", s));
            end
        endcase
    endtask

    // Wait for the block to go idle, then write one register
    task automatic write_reg(input t_reg_idx sel, input logic [15:0] data);
        i_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (sel)
            REG_THRESHOLD: cfg_thr  = data;
            REG_SYNC_MIN:  cfg_smin = data;
            REG_SYNC_MAX:  cfg_smax = data;
            default:       cfg_cnt  = data[4:0];
        endcase
    endtask

    function automatic logic signed [15:0] level_sample(input bit want_high);
        int t;
        int pick;
        t    = cfg_thr;
        pick = $urandom_range(7);
        if (want_high && t < 32767) begin
            if (pick == 0)
                return 16'sh7FFF;
            if (pick == 1)
                return 16'(t + 1);
            return 16'(t + 1 + int'($urandom_range(32766 - t)));
        end
        if (pick == 0)
            return 16'sh8000;
        if (pick == 1)
            return 16'(t);
        return 16'(-32768 + int'($urandom_range(t + 32768)));
    endfunction

    task automatic drive_run(input bit want_high, input int len);
        for (int k = 0; k < len; k++)
            push_sample(level_sample(want_high), EXP_MODEL, NO_WORD);
    endtask

    function automatic int short_len();
        return $urandom_range(cfg_smin > 1 ? cfg_smin - 1 : 1, 1);
    endfunction

    function automatic int sync_len();
        int lo;
        int hi;
        lo = cfg_smin;
        if (cfg_smax >= cfg_smin) begin
            hi = cfg_smax;
            if (hi > lo + 12)
                hi = lo + 12;
        end else begin
            hi = lo + 3;
        end
        return $urandom_range(hi, lo);
    endfunction

    task automatic drive_channels(input int n);
        for (int c = 0; c < n; c++) begin
            drive_run(1'b1, short_len());
            drive_run(1'b0, short_len());
        end
    endtask

    // Mostly whole frames, some cut short by a stray pulse, some plain noise
    task automatic run_frames(input int budget);
        int first;
        int pick;
        int chans;
        first = samples_sent;
        while (samples_sent - first < budget) begin
            pick  = $urandom_range(9);
            chans = channels_per_frame();
            if (pick < 7) begin
                drive_run(1'b0, sync_len());
                drive_channels(chans);
                drive_run(1'b1, short_len());
            end else if (pick < 9) begin
                drive_run(1'b0, sync_len());
                drive_channels($urandom_range(chans - 1));
                drive_run(1'($urandom_range(1)), $urandom_range(cfg_smin + 3, 1));
            end else begin
                repeat ($urandom_range(6, 1))
                    drive_run(1'($urandom_range(1)), $urandom_range(24, 1));
            end
        end
        // Leave half the phases mid-frame so the next settings land on a live frame
        if ($urandom_range(1)) begin
            drive_run(1'b0, sync_len());
            drive_channels($urandom_range(channels_per_frame()));
        end
    endtask

    task automatic choose_settings(input int phase);
        logic [15:0] thr;
        logic [15:0] smin;
        logic [15:0] smax;
        logic [4:0]  cnt;
        int          pick;
        case (phase)
            0: begin
                thr = 16'h8000; smin = 16'd1;  smax = 16'd1;     cnt = 5'd3;
            end
            1: begin
                thr = 16'd32766; smin = 16'd3; smax = 16'hFFFF;  cnt = 5'd16;
            end
            2: begin
                thr = 16'h7FFF; smin = 16'd5;  smax = 16'd9;     cnt = 5'd31;
            end
            3: begin
                thr = 16'($urandom); smin = 16'd2; smax = 16'd2; cnt = 5'd0;
            end
            4: begin
                thr = 16'd0;    smin = 16'd6;  smax = 16'd10;    cnt = 5'd20;
            end
            default: begin
                pick = $urandom_range(9);
                thr  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'h8000 :
                       (pick == 2) ? 16'h7FFE : 16'($urandom);
                if (thr == 16'h7FFF)
                    thr = 16'h7FFE;
                smin = 16'($urandom_range(12, 2));
                pick = $urandom_range(7);
                smax = (pick == 0) ? 16'($urandom_range(smin - 1, 1)) :
                       (pick == 1) ? 16'hFFFF : smin + 16'($urandom_range(10));
                pick = $urandom_range(9);
                cnt  = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(31, 17)) :
                       (pick == 2) ? 5'd16 : 5'($urandom_range(6, 1));
            end
        endcase
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SYNC_MIN, smin);
        write_reg(REG_SYNC_MAX, smax);
        write_reg(REG_CHAN_CNT, {11'd0, cnt});
        settings_used++;
    endtask

    // Stall the result side at random, except through the steady stretch
    always @(posedge i_clk)
        i_ready <= steady_flow() || ($urandom_range(99) >= IDLE_PCT);

    // Check each accepted channel word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (words_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected word chan %0d sum %0d last %0b",
                                        o_channel_index, o_channel_value, o_last_of_frame));
            end else begin
                word_want = words_due.pop_front();
                if (o_channel_index !== word_want.chan)
                    flag_mismatch($sformatf("channel_index %0d, want %0d",
                                            o_channel_index, word_want.chan));
                if (o_channel_value !== word_want.sum)
                    flag_mismatch($sformatf("channel_value %0d, want %0d",
                                            o_channel_value, word_want.sum));
                if (o_last_of_frame !== word_want.last)
                    flag_mismatch($sformatf("last_of_frame %0b, want %0b",
                                            o_last_of_frame, word_want.last));
                words_checked++;
            end
        end
    end

    initial begin
        int phase;
        int words_before;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample        = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_THRESHOLD;
        i_cfg_data      = '0;
        samples_sent    = 0;
        words_predicted = 0;
        words_checked   = 0;
        settings_used   = 1;
        mismatches      = 0;
        reset_decoder();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (DIRECTED_STEPS[r].kind == ROW_WRITE)
                write_reg(DIRECTED_STEPS[r].sel, DIRECTED_STEPS[r].data);
            else
                push_sample(DIRECTED_STEPS[r].data, DIRECTED_STEPS[r].how,
                            DIRECTED_STEPS[r].word);
        end

        // Random pulse trains, one register setting per phase
        phase        = 0;
        words_before = words_predicted;
        while ((samples_sent < SCRIPT_LEN + RANDOM_SAMPLES
                || words_predicted - words_before < RANDOM_WORDS) && phase < 200) begin
            choose_settings(phase);
            run_frames($urandom_range(120, 60));
            phase++;
        end

        // Drain the remaining words
        i_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d samples across %0d register settings, with output stalls;",
                 samples_sent, settings_used);
        $display("checked %0d channel words, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
